### rtl/swlm_pkg.sv
// swlm_pkg: shared types and constants of the sliding window lower median filter
// no dependencies; imported by swlm_cell and the top level
package swlm_pkg;

    // width of the window length register as seen on the config port
    localparam int CFG_BITS = 7;
    // window length after reset
    localparam int LEN_RESET = 3;
    // number of cells folded into one first-level median select group
    localparam int GROUP_SIZE = 8;

    // controls broadcast from the top level to every cell
    typedef struct packed {
        logic en;          // a sample is accepted this cycle
        logic start;       // the sample opens a new series, old contents ignored
        logic rem;         // window is full, the oldest sample leaves
        logic rem_le_key;  // leaving sample sorts at or below the new sample
        logic flush;       // window length written, empty the window
    } cell_ctl_t;

    // compare results one cell shows its neighbors
    typedef struct packed {
        logic valid;  // cell holds a sample of the current series
        logic le;     // cell value is at or below the new sample
        logic atd;    // leaving sample sits at or below this position
    } cell_flags_t;

endpackage

### rtl/sliding_window_lower_median_top.sv
// sliding_window_lower_median_top: running lower median filter, top level
// depends on swlm_pkg, swlm_ram (arrival ring) and swlm_cell (sorted chain)
//
// usage
//   input channel: sample, start_of_series with sample_valid / sample_stall.
//   a word is taken at a rising edge with sample_valid high and sample_stall low.
//   output channel: median with median_valid / median_stall, same rule.
//   window_len is written with window_len_we, only while the block is idle;
//   zero counts as one, values above WINDOW_MAX saturate, and every write
//   empties the window as a new series would.
//   start_of_series empties the window before its sample is taken.
//   no word comes out until the window holds window_len samples; from then
//   on every input word gives one median word (rank (len+1)/2, lower median).
// timing
//   one input word per cycle while sample_stall is low: the sorted window
//   is a chain of WINDOW_MAX cells that does remove-and-insert in one step,
//   each cell looking only at its two neighbors and the broadcast sample.
//   the accepting edge updates the cells, then the group select (groups of 8
//   cells) is registered, then the output register.
// reset and stall
//   reset empties the window, sets window_len to 3 and drops all pending words.
//   a stalled output holds its word; one more result waits in the group select
//   and one in the cells, then sample_stall rises and the window stays put.
module sliding_window_lower_median_top #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_len_we,
    input  logic [swlm_pkg::CFG_BITS-1:0] window_len,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          start_of_series,
    output logic                          median_valid,
    input  logic                          median_stall,
    output logic signed [SAMPLE_BITS-1:0] median
);

    import swlm_pkg::*;

    localparam int W   = SAMPLE_BITS;
    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW  = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int GN  = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int LEN_RST = (LEN_RESET < WINDOW_MAX) ? LEN_RESET : WINDOW_MAX;
    localparam int MED_RST = (LEN_RST + 1) / 2 - 1;

    // window bookkeeping
    logic [CW-1:0]         len_reg, len_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [WINDOW_MAX-1:0] med_sel_reg, med_sel_next;

    // step decode
    logic            acc;
    logic [CW-1:0]   fill_eff;
    logic [CW-1:0]   fill_after;
    logic [PW-1:0]   ptr_eff;
    logic [PW-1:0]   ptr_after;
    logic [CW-1:0]   ptr_inc;
    logic            full_before;
    logic            has_result;
    logic [LW-1:0]   cfg_ext;
    logic [CW-1:0]   len_cfg;
    logic [CW:0]     med_idx;

    // oldest sample from the arrival ring, with write-through bypass
    logic [W-1:0]    ram_rdata;
    logic [W-1:0]    rm_val;
    logic            fwd_reg;
    logic [W-1:0]    fwd_data_reg;

    // cell chain
    cell_ctl_t             ctl;
    logic [W-1:0]          cell_val   [WINDOW_MAX];
    cell_flags_t           cell_flags [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] cell_live;

    // result pipeline: cells, group select, output word
    logic            r0_valid_reg, r0_valid_next;
    logic            p1_valid_reg, p1_valid_next;
    logic [W-1:0]    p1_grp_reg [GN];
    logic [W-1:0]    grp_or [GN];
    logic            median_valid_reg, median_valid_next;
    logic [W-1:0]    median_reg;
    logic [W-1:0]    final_or;
    logic            out_moves, out_free, p1_moves, p1_free, r0_moves;

    // handshake chain, one free slot ahead is enough to take a word
    always_comb
    begin
        out_moves    = median_valid_reg && !median_stall;
        out_free     = !median_valid_reg || out_moves;
        p1_moves     = p1_valid_reg && out_free;
        p1_free      = !p1_valid_reg || p1_moves;
        r0_moves     = r0_valid_reg && p1_free;
        sample_stall = r0_valid_reg && !p1_free;
        acc          = sample_valid && !sample_stall;
    end

    // fill count, oldest pointer, result decision
    always_comb
    begin
        fill_eff    = start_of_series ? '0 : fill_reg;
        ptr_eff     = start_of_series ? '0 : ptr_reg;
        full_before = (fill_eff == len_reg);
        fill_after  = full_before ? fill_eff : fill_eff + CW'(1);
        has_result  = (fill_after == len_reg);
        ptr_inc     = CW'(ptr_eff) + CW'(1);
        ptr_after   = (ptr_inc >= len_reg) ? '0 : PW'(ptr_inc);
    end

    // window length write: clamp to 1..WINDOW_MAX and pick the median cell
    always_comb
    begin
        cfg_ext = LW'(window_len);
        if (cfg_ext == '0)
        begin
            len_cfg = CW'(1);
        end
        else if (cfg_ext > LW'(WINDOW_MAX))
        begin
            len_cfg = CW'(WINDOW_MAX);
        end
        else
        begin
            len_cfg = CW'(cfg_ext);
        end
        med_idx = (({1'b0, len_cfg} + (CW + 1)'(1)) >> 1) - (CW + 1)'(1);
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            med_sel_next[i] = (med_idx == (CW + 1)'(i));
        end
    end

    always_comb
    begin
        len_next  = len_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (window_len_we)
        begin
            len_next  = len_cfg;
            fill_next = '0;
            ptr_next  = '0;
        end
        else if (acc)
        begin
            fill_next = fill_after;
            ptr_next  = ptr_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= CW'(LEN_RST);
            fill_reg <= '0;
            ptr_reg  <= '0;
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                med_sel_reg[i] <= (i == MED_RST);
            end
        end
        else
        begin
            len_reg  <= len_next;
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (window_len_we)
            begin
                med_sel_reg <= med_sel_next;
            end
        end
    end

    // arrival ring: the new sample overwrites the oldest slot, the read port
    // already fetches the slot that will be oldest at the next word
    swlm_ram #(
        .WIDTH (W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (acc),
        .waddr (ptr_eff),
        .wdata (sample),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    // same-slot read and write (window of one) takes the written word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= acc && (ptr_eff == ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= sample;
    end

    assign rm_val = fwd_reg ? fwd_data_reg : ram_rdata;

    // broadcast controls for the cell chain
    always_comb
    begin
        ctl.en         = acc;
        ctl.start      = start_of_series;
        ctl.rem        = full_before;
        ctl.rem_le_key = full_before && ($signed(rm_val) <= $signed(sample));
        ctl.flush      = window_len_we;
    end

    // sorted window: cell 0 holds the smallest sample
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [W-1:0] lv;
        cell_flags_t  lf;
        logic [W-1:0] rv;
        cell_flags_t  rf;

        if (i == 0)
        begin : g_lo
            assign lv = '0;
            assign lf = '{valid: 1'b1, le: 1'b1, atd: 1'b0};
        end
        else
        begin : g_lo
            assign lv = cell_val[i-1];
            assign lf = cell_flags[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_hi
            assign rv = '0;
            assign rf = '{valid: 1'b0, le: 1'b0, atd: 1'b0};
        end
        else
        begin : g_hi
            assign rv = cell_val[i+1];
            assign rf = cell_flags[i+1];
        end

        swlm_cell #(
            .W (W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (sample),
            .rm_val      (rm_val),
            .left_val    (lv),
            .left_flags  (lf),
            .right_val   (rv),
            .right_flags (rf),
            .val         (cell_val[i]),
            .flags       (cell_flags[i]),
            .live        (cell_live[i])
        );
    end

    // median select, first level: one-hot mask and or inside each group
    always_comb
    begin
        for (int g = 0; g < GN; g++)
        begin
            grp_or[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < WINDOW_MAX)
                begin
                    grp_or[g] = grp_or[g] | (cell_val[g * GROUP_SIZE + j]
                                & {W{med_sel_reg[g * GROUP_SIZE + j]}});
                end
            end
        end
    end

    // median select, second level: or across groups
    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < GN; g++)
        begin
            final_or = final_or | p1_grp_reg[g];
        end
    end

    always_comb
    begin
        r0_valid_next = r0_valid_reg;
        if (acc)
        begin
            r0_valid_next = has_result;
        end
        else if (r0_moves)
        begin
            r0_valid_next = 1'b0;
        end

        p1_valid_next = p1_valid_reg;
        if (r0_moves)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_moves)
        begin
            p1_valid_next = 1'b0;
        end

        median_valid_next = median_valid_reg;
        if (p1_moves)
        begin
            median_valid_next = 1'b1;
        end
        else if (out_moves)
        begin
            median_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg     <= 1'b0;
            p1_valid_reg     <= 1'b0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            r0_valid_reg     <= r0_valid_next;
            p1_valid_reg     <= p1_valid_next;
            median_valid_reg <= median_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r0_moves)
        begin
            for (int g = 0; g < GN; g++)
            begin
                p1_grp_reg[g] <= grp_or[g];
            end
        end
        if (p1_moves)
        begin
            median_reg <= final_or;
        end
    end

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

    // checks on the window bookkeeping
    a_fill_in_len : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_reg)
        else $error("fill count above window length");

    a_ptr_in_len : assert property (@(posedge clk) disable iff (!rst_n)
        CW'(ptr_reg) < len_reg)
        else $error("oldest pointer outside the window");

    a_cells_match_fill : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_live) == int'(fill_reg))
        else $error("occupied cells differ from fill count");

    a_med_sel_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(med_sel_reg))
        else $error("median select not one-hot");

endmodule

### rtl/swlm_ram.sv
// swlm_ram: generic single write, single read RAM with registered read data
// no dependencies
module swlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/swlm_cell.sv
// swlm_cell: one position of the sorted window chain
// depends on swlm_pkg for the control and neighbor flag structs
module swlm_cell #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swlm_pkg::cell_ctl_t    ctl,
    input  logic [W-1:0]           key,
    input  logic [W-1:0]           rm_val,
    input  logic [W-1:0]           left_val,
    input  swlm_pkg::cell_flags_t  left_flags,
    input  logic [W-1:0]           right_val,
    input  swlm_pkg::cell_flags_t  right_flags,
    output logic [W-1:0]           val,
    output swlm_pkg::cell_flags_t  flags,
    output logic                   live
);

    import swlm_pkg::*;

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic         valid_reg;
    logic         valid_next;
    logic         v;

    always_comb
    begin
        v = valid_reg && !ctl.start;
        flags.valid = v;
        flags.le = v && ($signed(val_reg) <= $signed(key));
        flags.atd = ctl.rem && (!v || ($signed(val_reg) >= $signed(rm_val)));
    end

    always_comb
    begin
        val_next = val_reg;
        if (ctl.rem_le_key)
        begin
            // leaving sample is below: close the gap upward, new sample at the top
            if (flags.le && flags.atd)
            begin
                val_next = right_flags.le ? right_val : key;
            end
        end
        else
        begin
            // new sample goes in first, larger values move up to the gap
            if (!flags.le)
            begin
                if (left_flags.le)
                begin
                    val_next = key;
                end
                else if (!left_flags.atd)
                begin
                    val_next = left_val;
                end
            end
        end
        valid_next = ctl.rem ? v : (v || left_flags.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
        end
    end

    assign val  = val_reg;
    assign live = valid_reg;

endmodule

### verif/tb_sliding_window_lower_median_top.sv
// tb_sliding_window_lower_median_top: self-checking testbench of the running lower median filter
// depends on swlm_pkg and sliding_window_lower_median_top; uses its own median predictor
// directed words first, then random phases over several window lengths and gap patterns
module tb_sliding_window_lower_median_top;

    // one input word as the stimulus process queues it
    typedef struct {
        logic signed [31:0] value;
        logic               sos;
    } sample_word_t;

    // gap patterns on the two channels
    typedef enum {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } gap_mode_t;

    localparam int WIN_MAX      = 64;
    localparam int CLK_HALF     = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 300000;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          window_len_we   = 1'b0;
    logic [swlm_pkg::CFG_BITS-1:0] window_len      = '0;
    logic                          sample_valid    = 1'b0;
    logic                          sample_stall;
    logic signed [31:0]            sample          = '0;
    logic                          start_of_series = 1'b0;
    logic                          median_valid;
    logic                          median_stall    = 1'b0;
    logic signed [31:0]            median;

    // words waiting to be offered, and medians waiting to come out
    sample_word_t       sample_words_q[$];
    logic signed [31:0] median_expected_q[$];

    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: requested by the stimulus, counted by the stall process
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;

    // predictor state: window in arrival order and in ascending order
    logic signed [31:0]            win_ring[WIN_MAX];
    logic signed [31:0]            win_sorted[WIN_MAX];
    int unsigned                   win_fill   = 0;
    int unsigned                   win_oldest = 0;
    logic [swlm_pkg::CFG_BITS-1:0] win_len_reg = (swlm_pkg::CFG_BITS)'(swlm_pkg::LEN_RESET);

    sliding_window_lower_median_top #(
        .WINDOW_MAX  (WIN_MAX),
        .SAMPLE_BITS (32)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_len_we   (window_len_we),
        .window_len      (window_len),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .start_of_series (start_of_series),
        .median_valid    (median_valid),
        .median_stall    (median_stall),
        .median          (median)
    );

    always #CLK_HALF clk = ~clk;

    // length actually used: zero counts as one, large values saturate
    function automatic int unsigned eff_len(input logic [swlm_pkg::CFG_BITS-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > WIN_MAX)
            return WIN_MAX;
        return 32'(raw);
    endfunction

    // advance the window by one accepted word and give its median, if any
    task automatic compute_median(
        input  logic signed [31:0] s,
        input  logic               sos,
        output bit                 produced,
        output logic signed [31:0] med
    );
        int unsigned        len;
        int unsigned        n;
        int unsigned        i;
        int unsigned        idx;
        logic signed [31:0] leaving;
        len = eff_len(win_len_reg);
        if (sos)
        begin
            win_fill   = 0;
            win_oldest = 0;
        end
        if (win_fill > len)
            win_fill = len;
        if (win_oldest >= len)
            win_oldest = 0;
        if (win_fill < len)
        begin
            n = win_fill;
            win_fill++;
        end
        else
        begin
            // drop one copy of the leaving word from the sorted window
            leaving = win_ring[win_oldest];
            idx     = len - 1;
            for (i = 0; i < len; i++)
            begin
                if (win_sorted[i] == leaving)
                begin
                    idx = i;
                    break;
                end
            end
            for (i = idx; i + 1 < len; i++)
                win_sorted[i] = win_sorted[i + 1];
            n = len - 1;
        end
        // insertion into the n entries still held
        i = n;
        while (i > 0 && win_sorted[i - 1] > s)
        begin
            win_sorted[i] = win_sorted[i - 1];
            i--;
        end
        win_sorted[i] = s;
        win_ring[win_oldest] = s;
        win_oldest++;
        if (win_oldest >= len)
            win_oldest = 0;
        produced = (win_fill >= len);
        med      = win_sorted[(len + 1) / 2 - 1];
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb_sliding_window_lower_median_top: %s", msg);
        err_count++;
    endtask

    // driver: offers the queue head, predicts at acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit                 produced;
        logic signed [31:0] med;
        if (!rst_n)
        begin
            sample_valid    <= 1'b0;
            sample          <= '0;
            start_of_series <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                compute_median(sample, start_of_series, produced, med);
                if (produced)
                    median_expected_q.insert(median_expected_q.size(), med);
                void'(sample_words_q.pop_front());
            end
            // a stalled word stays put, otherwise pick the next one or a gap
            if (!sample_valid || !sample_stall)
            begin
                if (sample_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_valid    <= 1'b1;
                    sample          <= sample_words_q[0].value;
                    start_of_series <= sample_words_q[0].sos;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random pattern, plus one long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_stall <= 1'b0;
            hold_left    <= 0;
            hold_taken   <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken   <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            median_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            median_stall <= 1'b1;
        end
        else
            median_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: every accepted median word against the oldest prediction
    always @(posedge clk)
    begin : watch
        logic signed [31:0] want;
        if (rst_n && median_valid && !median_stall)
        begin
            if (median_expected_q.size() == 0)
                report_mismatch($sformatf("median %0d with none expected", median));
            else
            begin
                want = median_expected_q.pop_front();
                if (median !== want)
                    report_mismatch($sformatf("median got %0d, expected %0d", median, want));
            end
        end
    end

    task automatic set_gaps(input gap_mode_t mode);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        case (mode)
            GAP_SENDER:   send_idle_pct  = 48;
            GAP_RECEIVER: recv_stall_pct = 48;
            GAP_BOTH:
            begin
                send_idle_pct  = 8;
                recv_stall_pct = 8;
            end
            default: ;
        endcase
    endtask

    task automatic push_word(input logic signed [31:0] v, input logic sos);
        sample_word_t w;
        w.value = v;
        w.sos   = sos;
        sample_words_q.insert(sample_words_q.size(), w);
    endtask

    // all words taken, all medians out, then room for the pipeline to settle
    task automatic wait_drained();
        @(negedge clk);
        while (sample_words_q.size() != 0 || sample_valid || median_expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write while idle; the predictor empties its window as the block does
    task automatic write_len(input logic [swlm_pkg::CFG_BITS-1:0] v);
        @(posedge clk);
        window_len_we <= 1'b1;
        window_len    <= v;
        win_len_reg = v;
        win_fill    = 0;
        win_oldest  = 0;
        @(posedge clk);
        window_len_we <= 1'b0;
    endtask

    // extremes, sign edges, clustered small values (duplicates), and full-range noise
    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(9))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5:    return $signed($urandom_range(15)) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    // one random phase: idle, set the length, then queue n words
    task automatic run_phase(
        input logic [swlm_pkg::CFG_BITS-1:0] len,
        input gap_mode_t                     mode,
        input int                            n,
        input bit                            with_hold
    );
        int unsigned span;
        wait_drained();
        write_len(len);
        @(negedge clk);
        set_gaps(mode);
        if (with_hold)
            hold_req = 1'b1;
        // restarts rare enough that most series fill the window
        span = 4 * eff_len(len) + 20;
        for (int k = 0; k < n; k++)
            push_word(pick_sample(), $urandom_range(span) == 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_gaps(GAP_NONE);

        // reset length of three: extremes, equal words, short series
        push_word(S_MAX, 1'b1);
        push_word(S_MIN, 1'b0);
        push_word(32'sd0, 1'b0);
        push_word(-32'sd1, 1'b0);
        push_word(-32'sd1, 1'b0);
        push_word(-32'sd1, 1'b0);
        push_word(S_MIN, 1'b0);
        push_word(S_MAX, 1'b1);
        push_word(32'sd5, 1'b0);
        push_word(32'sd7, 1'b1);
        push_word(32'sd1, 1'b0);
        push_word(32'sd2, 1'b0);
        push_word(S_MAX, 1'b0);
        push_word(S_MAX, 1'b0);

        // zero length acts as one: every word is its own median
        wait_drained();
        write_len('0);
        @(negedge clk);
        push_word(S_MIN, 1'b0);
        push_word(S_MAX, 1'b1);
        push_word(32'sd0, 1'b0);

        // even length gives the lower of the two middle words
        wait_drained();
        write_len(2);
        @(negedge clk);
        push_word(32'sd4, 1'b0);
        push_word(32'sd3, 1'b0);
        push_word(S_MIN, 1'b0);
        push_word(S_MAX, 1'b0);
        push_word(S_MAX, 1'b1);

        run_phase(5,   GAP_NONE,     180, 1'b0);
        run_phase(64,  GAP_SENDER,   280, 1'b0);
        run_phase(1,   GAP_RECEIVER, 150, 1'b0);
        run_phase(2,   GAP_BOTH,     160, 1'b0);
        // saturating length with the long hold-off: the block has to back up
        run_phase(127, GAP_NONE,     320, 1'b1);
        run_phase(8,   GAP_SENDER,   160, 1'b0);
        run_phase(65,  GAP_RECEIVER, 200, 1'b0);
        run_phase(7,   GAP_BOTH,     200, 1'b0);
        run_phase(3,   GAP_SENDER,   180, 1'b0);

        wait_drained();
        if (err_count == 0 && median_expected_q.size() == 0)
            $display("tb_sliding_window_lower_median_top: done, clean");
        else
            $display("tb_sliding_window_lower_median_top: done, errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("tb_sliding_window_lower_median_top: done, errors");
        $finish;
    end

endmodule
